[hw/rtl/single_linkage_core_extension_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the single-linkage core extension block
// Each macro checks one property on the rising clock edge, outside reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_LINKAGE_CORE_EXTENSION_TOP_ASSERT_SVH
`define SINGLE_LINKAGE_CORE_EXTENSION_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// plain property
`define SLCE_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("slce assertion failed");

// same-cycle implication
`define SLCE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slce implication failed");

// next-cycle implication
`define SLCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slce next-cycle implication failed");

`else

`define SLCE_ASSERT(label, clk, rstn, prop)
`define SLCE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SLCE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/slce_pkg.sv]
// ----------------------------------------------------------------------------
// slce_pkg
// Shared types and constants of the single-linkage core extension block.
// ----------------------------------------------------------------------------
package slce_pkg;

  // number of point cells in the chain
  localparam int unsigned NCELL   = 64;
  localparam int unsigned IDX_W   = $clog2(NCELL);
  localparam int unsigned CNT_W   = $clog2(NCELL + 1);
  // one round: pass load, NCELL compare steps, two drain steps, commit
  localparam int unsigned STEP_W  = $clog2(NCELL + 4);

  localparam int unsigned COORD_W = 20;
  localparam int unsigned MAG_W   = COORD_W;          // |difference| < 2^20
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned SUM_W   = SQ_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [SUM_W-1:0]          sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // token that circulates around the ring during growth
  typedef struct packed {
    point_t pt;
    logic   front;
  } pass_t;

  // slot contents moved toward the head during output
  typedef struct packed {
    point_t pt;
    logic   occ;
    logic   member;
  } slot_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic load_pass;
    logic cmp_en;
    logic round_end;
    logic shift;
    logic clear;
  } cell_cmd_t;

  // reduced status of the chain seen by the controller
  typedef struct packed {
    logic any_member;
    logic rest_member;
    logic any_added;
  } chain_stat_t;

  // magnitude of the difference of two coordinates
  function automatic logic [MAG_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[MAG_W-1:0];
  endfunction

endpackage

[hw/rtl/slce_cell.sv]
// ----------------------------------------------------------------------------
// slce_cell
// One point slot: stores a point and its membership, compares it against the
// token passing through, and moves its contents along the chain.
// ----------------------------------------------------------------------------
`include "single_linkage_core_extension_top_assert.svh"

module slce_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slce_pkg::cell_cmd_t cmd_i,
  input  logic                wr_en_i,
  input  slce_pkg::point_t    wr_point_i,
  input  logic                wr_core_i,
  input  slce_pkg::sq_t       limit_sq_i,
  input  slce_pkg::pass_t     pass_i,
  output slce_pkg::pass_t     pass_o,
  input  slce_pkg::slot_t     slot_i,
  output slce_pkg::slot_t     slot_o,
  output logic                member_o,
  output logic                added_o
);
  import slce_pkg::*;

  // stored point and flags
  point_t point_q, point_d;
  logic   occ_q, occ_d;
  logic   member_q, member_d;
  logic   front_q, front_d;
  logic   added_q, added_d;

  // ring token and distance pipeline
  pass_t  pass_q, pass_d;
  logic   s1_v_q, s1_v_d;
  logic [MAG_W-1:0] dx_q, dy_q, dz_q;
  logic   s2_v_q, s2_v_d;
  sq_t    sx_q, sy_q, sz_q;
  sum_t   dist_sum;
  logic   hit;

  // slot update: clear, load, shift toward head, round commit, mark on hit
  always_comb begin
    point_d  = point_q;
    occ_d    = occ_q;
    member_d = member_q;
    front_d  = front_q;
    added_d  = added_q;
    if (cmd_i.clear) begin
      occ_d    = 1'b0;
      member_d = 1'b0;
      front_d  = 1'b0;
      added_d  = 1'b0;
    end else if (wr_en_i) begin
      point_d  = wr_point_i;
      occ_d    = 1'b1;
      member_d = wr_core_i;
      front_d  = wr_core_i;
    end else if (cmd_i.shift) begin
      point_d  = slot_i.pt;
      occ_d    = slot_i.occ;
      member_d = slot_i.member;
    end else if (cmd_i.round_end) begin
      member_d = member_q | added_q;
      front_d  = added_q;
      added_d  = 1'b0;
    end else if (hit) begin
      added_d  = 1'b1;
    end
  end

  // ring token: own point at round start, then take the neighbor's
  always_comb begin
    pass_d = pass_q;
    if (cmd_i.load_pass) begin
      pass_d.pt    = point_q;
      pass_d.front = front_q & occ_q;
    end else if (cmd_i.cmp_en) begin
      pass_d = pass_i;
    end
  end

  // stage 1 qualifies the compare; stage 3 is the sum and limit check
  assign s1_v_d   = cmd_i.cmp_en & pass_q.front & occ_q & ~member_q;
  assign s2_v_d   = s1_v_q;
  assign dist_sum = SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);
  assign hit      = s2_v_q & (dist_sum <= SUM_W'(limit_sq_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q        <= 1'b0;
      member_q     <= 1'b0;
      front_q      <= 1'b0;
      added_q      <= 1'b0;
      pass_q       <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
    end else begin
      occ_q        <= occ_d;
      member_q     <= member_d;
      front_q      <= front_d;
      added_q      <= added_d;
      pass_q       <= pass_d;
      s1_v_q       <= s1_v_d;
      s2_v_q       <= s2_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    point_q   <= point_d;
    dx_q      <= abs_diff(point_q.x, pass_q.pt.x);
    dy_q      <= abs_diff(point_q.y, pass_q.pt.y);
    dz_q      <= abs_diff(point_q.z, pass_q.pt.z);
    sx_q      <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sy_q      <= SQ_W'(dy_q) * SQ_W'(dy_q);
    sz_q      <= SQ_W'(dz_q) * SQ_W'(dz_q);
  end

  assign pass_o      = pass_q;
  assign slot_o.pt     = point_q;
  assign slot_o.occ    = occ_q;
  assign slot_o.member = member_q;
  assign member_o    = member_q;
  assign added_o     = added_q;

  // checks
  `SLCE_ASSERT_IMPL(a_added_fresh, clk_i, rst_ni, added_q, occ_q && !member_q)
  `SLCE_ASSERT_IMPL(a_front_member, clk_i, rst_ni, front_q, member_q)
  `SLCE_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, cmd_i.clear, !member_q && !occ_q)

endmodule

[hw/rtl/slce_ctrl.sv]
// ----------------------------------------------------------------------------
// slce_ctrl
// Sequencer of the block: load, growth rounds, output scan, plus the
// configuration register and the output register.
// ----------------------------------------------------------------------------
`include "single_linkage_core_extension_top_assert.svh"

module slce_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [19:0]            cfg_extension_distance_i,
  // input handshake
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   last_point_i,
  // chain side
  output slce_pkg::cell_cmd_t    cmd_o,
  output logic                   wr_en_o,
  output logic [slce_pkg::IDX_W-1:0] wr_idx_o,
  output slce_pkg::sq_t          limit_sq_o,
  input  slce_pkg::chain_stat_t  stat_i,
  input  slce_pkg::slot_t        head_i,
  // result
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output slce_pkg::point_t       out_point_o,
  output logic                   out_last_o,
  output logic                   out_empty_o,
  output logic                   out_ovf_o
);
  import slce_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_GROW  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              ovf_q, ovf_d;
  logic [19:0]       dist_q;
  sq_t               limit_sq_q;

  logic              out_valid_q, out_valid_d;
  point_t            out_point_q;
  logic              out_last_q, out_empty_q, out_ovf_q;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  point_t            out_point_d;
  logic              out_last_d, out_empty_d;
  cell_cmd_t         cmd;

  assign in_acc   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    ovf_d       = ovf_q;
    cmd         = '0;
    wr_en_o     = 1'b0;
    out_load    = 1'b0;
    out_point_d = head_i.pt;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          if (count_q < CNT_W'(NCELL)) begin
            wr_en_o = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_point_i) begin
            state_d = ST_GROW;
            step_d  = '0;
          end
        end
      end
      ST_GROW: begin
        cmd.load_pass = (step_q == '0);
        cmd.cmp_en    = (step_q != '0) && (step_q <= STEP_W'(NCELL));
        cmd.round_end = (step_q == STEP_W'(NCELL + 3));
        step_d        = step_q + 1'b1;
        if (cmd.round_end) begin
          step_d = '0;
          if (!stat_i.any_added) begin
            state_d = stat_i.any_member ? ST_EMIT : ST_EMPTY;
          end
        end
      end
      ST_EMIT: begin
        if (!stat_i.any_member) begin
          cmd.clear = 1'b1;
          state_d   = ST_LOAD;
          count_d   = '0;
          ovf_d     = 1'b0;
        end else begin
          cmd.shift  = head_i.member ? out_free : 1'b1;
          out_load   = head_i.member & out_free;
          out_last_d = ~stat_i.rest_member;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_point_d = '0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          cmd.clear   = 1'b1;
          state_d     = ST_LOAD;
          count_d     = '0;
          ovf_d       = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      step_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        dist_q <= cfg_extension_distance_i;
      end
    end
  end

  // squared limit and result payload
  always_ff @(posedge clk_i) begin
    limit_sq_q <= SQ_W'(dist_q) * SQ_W'(dist_q);
    if (out_load) begin
      out_point_q <= out_point_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= ovf_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cmd_o       = cmd;
  assign wr_idx_o    = count_q[IDX_W-1:0];
  assign limit_sq_o  = limit_sq_q;
  assign out_valid_o = out_valid_q;
  assign out_point_o = out_point_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;
  assign out_ovf_o   = out_ovf_q;

  // checks
  `SLCE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CNT_W'(NCELL))
  `SLCE_ASSERT(a_step_range, clk_i, rst_ni, step_q <= STEP_W'(NCELL + 3))
  `SLCE_ASSERT_IMPL(a_empty_is_last, clk_i, rst_ni, out_valid_q && out_empty_q, out_last_q)

endmodule

[hw/rtl/single_linkage_core_extension_top.sv]
// ----------------------------------------------------------------------------
// single_linkage_core_extension_top
// Grows a core of 3D points by single linkage and streams out the kept ones.
// ----------------------------------------------------------------------------
// Points are taken one per cycle into a chain of 64 cells, each cell holding
// one point. After the point marked last, growth runs in rounds: every
// cell's point circulates once around the ring while each cell checks it
// against its own point through a three-stage distance pipeline, and rounds
// repeat until one adds no point. The chain then shifts toward the head,
// dropping points that were not kept and giving kept ones in input order;
// a kept point waits at the head while the output stalls, and the chain is
// then cleared before the next set is taken. An empty core gives a single
// marker result. No point is taken during growth or output; configuration
// is taken at any cycle.
`include "single_linkage_core_extension_top_assert.svh"

module single_linkage_core_extension_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [19:0]         cfg_extension_distance_i,
  // points in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [19:0]  coord_x_i,
  input  logic signed [19:0]  coord_y_i,
  input  logic signed [19:0]  coord_z_i,
  input  logic                in_core_i,
  input  logic                last_point_i,
  // kept points out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [19:0]  kept_x_o,
  output logic signed [19:0]  kept_y_o,
  output logic signed [19:0]  kept_z_o,
  output logic                last_kept_o,
  output logic                empty_set_o,
  output logic                overflowed_o
);
  import slce_pkg::*;

  cell_cmd_t        cmd;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  sq_t              limit_sq;
  chain_stat_t      stat;
  point_t           wr_point;
  point_t           out_point;

  pass_t            pass_out [NCELL];
  slot_t            slot_out [NCELL];
  logic [NCELL-1:0] member_vec;
  logic [NCELL-1:0] added_vec;

  assign wr_point.x = coord_x_i;
  assign wr_point.y = coord_y_i;
  assign wr_point.z = coord_z_i;

  // chain status
  assign stat.any_member  = |member_vec;
  assign stat.rest_member = |member_vec[NCELL-1:1];
  assign stat.any_added   = |added_vec;

  slce_ctrl u_ctrl (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_extension_distance_i (cfg_extension_distance_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .last_point_i             (last_point_i),
    .cmd_o                    (cmd),
    .wr_en_o                  (wr_en),
    .wr_idx_o                 (wr_idx),
    .limit_sq_o               (limit_sq),
    .stat_i                   (stat),
    .head_i                   (slot_out[0]),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .out_point_o              (out_point),
    .out_last_o               (last_kept_o),
    .out_empty_o              (empty_set_o),
    .out_ovf_o                (overflowed_o)
  );

  // the cell chain: ring for growth, shift toward cell 0 for output
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? NCELL - 1 : i - 1;
    slot_t slot_in;
    logic  cell_we;

    if (i == NCELL - 1) begin : g_tail
      assign slot_in = '0;
    end else begin : g_mid
      assign slot_in = slot_out[i+1];
    end

    assign cell_we = wr_en & (wr_idx == IDX_W'(i));

    slce_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .wr_en_i    (cell_we),
      .wr_point_i (wr_point),
      .wr_core_i  (in_core_i),
      .limit_sq_i (limit_sq),
      .pass_i     (pass_out[PREV]),
      .pass_o     (pass_out[i]),
      .slot_i     (slot_in),
      .slot_o     (slot_out[i]),
      .member_o   (member_vec[i]),
      .added_o    (added_vec[i])
    );
  end

  assign kept_x_o = out_point.x;
  assign kept_y_o = out_point.y;
  assign kept_z_o = out_point.z;

  // checks
  `SLCE_ASSERT_IMPL(a_no_load_busy, clk_i, rst_ni, cmd.round_end || cmd.shift, !in_ready_o)
  `SLCE_ASSERT_IMPL(a_single_write, clk_i, rst_ni, wr_en, !cmd.shift && !cmd.clear)
  `SLCE_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_o && empty_set_o,
                    kept_x_o == '0 && kept_y_o == '0 && kept_z_o == '0)

endmodule
